// ===== rtl/crlf_line_command_decoder_unit_assert.svh =====
// Assertion macros for the CR-LF line command decoder.
`ifndef CRLF_LINE_COMMAND_DECODER_UNIT_ASSERT_SVH
`define CRLF_LINE_COMMAND_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CRLFCMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CRLFCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crlfcmd_pkg.sv =====
// Shared constants, types and keyword tables for the CR-LF line command decoder.
`timescale 1ns / 1ps

package crlfcmd_pkg;

  localparam int LINE_CAPACITY = 512;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);
  localparam int HEAD_DEPTH    = 13;
  localparam int KW_LEN_W      = $clog2(HEAD_DEPTH + 1);

  localparam logic [7:0] CHR_CR = 8'h0d;
  localparam logic [7:0] CHR_LF = 8'h0a;

  // element 0 is the first byte of the line
  typedef logic [0:HEAD_DEPTH-1][7:0] head_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [KW_LEN_W-1:0]        kw_len_t;

  // keywords, left aligned in a head-sized word
  localparam head_t KW_AT24HISTORY   = {"at24history", 16'h0};
  localparam head_t KW_STINW25       = {"stinw25", 48'h0};
  localparam head_t KW_W25HISTORY    = {"w25history", 24'h0};
  localparam head_t KW_SHOWPAGE2     = {"showpage2", 32'h0};
  localparam head_t KW_SHOWDATA      = {"showdata", 40'h0};
  localparam head_t KW_OPENFLOWLED   = {"openflowled", 16'h0};
  localparam head_t KW_CLOSEFLOWLED  = {"closeflowled", 8'h0};
  localparam head_t KW_OPENFLOWBEEP  = {"openflowbeep", 8'h0};
  localparam head_t KW_CLOSEFLOWBEEP = {"closeflowbeep"};
  localparam head_t KW_OPENFLOWFAN   = {"openflowfan", 16'h0};
  localparam head_t KW_CLOSEFLOWFAN  = {"closeflowfan", 8'h0};

  localparam kw_len_t LEN_AT24HISTORY   = kw_len_t'(11);
  localparam kw_len_t LEN_STINW25       = kw_len_t'(7);
  localparam kw_len_t LEN_W25HISTORY    = kw_len_t'(10);
  localparam kw_len_t LEN_SHOWPAGE2     = kw_len_t'(9);
  localparam kw_len_t LEN_SHOWDATA      = kw_len_t'(8);
  localparam kw_len_t LEN_OPENFLOWLED   = kw_len_t'(11);
  localparam kw_len_t LEN_CLOSEFLOWLED  = kw_len_t'(12);
  localparam kw_len_t LEN_OPENFLOWBEEP  = kw_len_t'(12);
  localparam kw_len_t LEN_CLOSEFLOWBEEP = kw_len_t'(13);
  localparam kw_len_t LEN_OPENFLOWFAN   = kw_len_t'(11);
  localparam kw_len_t LEN_CLOSEFLOWFAN  = kw_len_t'(12);

  typedef struct packed {
    logic eeprom_hist;
    logic flash_store;
    logic flash_hist;
    logic page_two;
    logic show_data;
    logic lamp_on;
    logic lamp_off;
    logic buzz_on;
    logic buzz_off;
    logic fan_on;
    logic fan_off;
  } kw_hits_t;

  typedef struct packed {
    logic line_done;
    logic frame_error;
    logic count_wrapped;
    logic ev_eeprom_history;
    logic ev_flash_store;
    logic ev_flash_history;
    logic ev_show_page_two;
    logic ev_show_data;
    logic lamp_level;
    logic buzzer_level;
    logic fan_level;
  } result_t;

  // prefix compare over the first len bytes of the head
  function automatic logic head_match(head_t head, head_t kw, kw_len_t len);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      if ((kw_len_t'(i) < len) && (head[i] != kw[i])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/crlfcmd_if.sv =====
// Valid/ready channel interfaces for the CR-LF line command decoder.
`timescale 1ns / 1ps

interface crlfcmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crlfcmd_out_if;
  logic valid;
  logic ready;
  logic line_done;
  logic frame_error;
  logic count_wrapped;
  logic ev_eeprom_history;
  logic ev_flash_store;
  logic ev_flash_history;
  logic ev_show_page_two;
  logic ev_show_data;
  logic lamp_level;
  logic buzzer_level;
  logic fan_level;

  modport source (
    output valid, input ready,
    output line_done, output frame_error, output count_wrapped,
    output ev_eeprom_history, output ev_flash_store, output ev_flash_history,
    output ev_show_page_two, output ev_show_data,
    output lamp_level, output buzzer_level, output fan_level
  );
  modport sink (
    input valid, output ready,
    input line_done, input frame_error, input count_wrapped,
    input ev_eeprom_history, input ev_flash_store, input ev_flash_history,
    input ev_show_page_two, input ev_show_data,
    input lamp_level, input buzzer_level, input fan_level
  );
endinterface

// ===== rtl/crlfcmd_match.sv =====
// Keyword prefix matcher over the stored line head.
`timescale 1ns / 1ps

module crlfcmd_match (
  input  crlfcmd_pkg::head_t    head_i,
  output crlfcmd_pkg::kw_hits_t hits_o
);
  import crlfcmd_pkg::*;

  assign hits_o.eeprom_hist = head_match(head_i, KW_AT24HISTORY,   LEN_AT24HISTORY);
  assign hits_o.flash_store = head_match(head_i, KW_STINW25,       LEN_STINW25);
  assign hits_o.flash_hist  = head_match(head_i, KW_W25HISTORY,    LEN_W25HISTORY);
  assign hits_o.page_two    = head_match(head_i, KW_SHOWPAGE2,     LEN_SHOWPAGE2);
  assign hits_o.show_data   = head_match(head_i, KW_SHOWDATA,      LEN_SHOWDATA);
  assign hits_o.lamp_on     = head_match(head_i, KW_OPENFLOWLED,   LEN_OPENFLOWLED);
  assign hits_o.lamp_off    = head_match(head_i, KW_CLOSEFLOWLED,  LEN_CLOSEFLOWLED);
  assign hits_o.buzz_on     = head_match(head_i, KW_OPENFLOWBEEP,  LEN_OPENFLOWBEEP);
  assign hits_o.buzz_off    = head_match(head_i, KW_CLOSEFLOWBEEP, LEN_CLOSEFLOWBEEP);
  assign hits_o.fan_on      = head_match(head_i, KW_OPENFLOWFAN,   LEN_OPENFLOWFAN);
  assign hits_o.fan_off     = head_match(head_i, KW_CLOSEFLOWFAN,  LEN_CLOSEFLOWFAN);

endmodule

// ===== rtl/crlf_line_command_decoder_unit.sv =====
// CR-LF line command decoder: takes one received byte per beat and gives one
// status beat per byte. Ordinary bytes are counted and the first 13 of a line
// kept; the count wraps to zero at 512. CR then LF ends a line and the kept head
// is prefix-matched against eleven command keywords, raising one-beat events or
// setting the lamp, buzzer and fan levels, and the head is cleared. CR followed
// by anything else drops that byte and flags a framing error. A byte can be
// taken every cycle while results drain. A byte is held in the input register
// and its status beat is then presented from the result register. A stalled
// result holds the input register, and the input stalls once both registers
// are full.
`timescale 1ns / 1ps
`include "crlf_line_command_decoder_unit_assert.svh"

module crlf_line_command_decoder_unit (
  input logic          clk,
  input logic          rst_n,
  crlfcmd_in_if.sink   in_ch,
  crlfcmd_out_if.source out_ch
);
  import crlfcmd_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire;

  // line state
  logic   cr_seen_r, cr_seen_nxt;
  count_t count_r, count_nxt;
  head_t  head_r, head_nxt;
  logic   lamp_r, lamp_nxt;
  logic   buzz_r, buzz_nxt;
  logic   fan_r, fan_nxt;

  logic [CNT_W:0] count_inc;
  kw_hits_t       hits;

  // result register
  logic    out_valid_r;
  result_t res_nxt;
  result_t out_res_r;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  crlfcmd_match u_match (
    .head_i (head_r),
    .hits_o (hits)
  );

  always_comb begin
    cr_seen_nxt = cr_seen_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    lamp_nxt    = lamp_r;
    buzz_nxt    = buzz_r;
    fan_nxt     = fan_r;
    res_nxt     = '0;
    count_inc   = {1'b0, count_r} + (CNT_W + 1)'(1);

    if (cr_seen_r) begin
      cr_seen_nxt = 1'b0;
      count_nxt   = '0;
      if (s1_byte_r != CHR_LF) begin
        res_nxt.frame_error = 1'b1;
      end else begin
        res_nxt.line_done         = 1'b1;
        res_nxt.ev_eeprom_history = hits.eeprom_hist;
        res_nxt.ev_flash_store    = hits.flash_store;
        res_nxt.ev_flash_history  = hits.flash_hist;
        res_nxt.ev_show_page_two  = hits.page_two;
        res_nxt.ev_show_data      = hits.show_data;
        if (hits.lamp_on)  lamp_nxt = 1'b1;
        if (hits.lamp_off) lamp_nxt = 1'b0;
        if (hits.buzz_on)  buzz_nxt = 1'b1;
        if (hits.buzz_off) buzz_nxt = 1'b0;
        if (hits.fan_on)   fan_nxt  = 1'b1;
        if (hits.fan_off)  fan_nxt  = 1'b0;
        head_nxt = '0;
      end
    end else if (s1_byte_r == CHR_CR) begin
      cr_seen_nxt = 1'b1;
    end else begin
      // positions past the head are counted only
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        if (count_r == CNT_W'(i)) begin
          head_nxt[i] = s1_byte_r;
        end
      end
      if (count_inc >= (CNT_W + 1)'(LINE_CAPACITY)) begin
        count_nxt             = '0;
        res_nxt.count_wrapped = 1'b1;
      end else begin
        count_nxt = count_inc[CNT_W-1:0];
      end
    end

    res_nxt.lamp_level   = lamp_nxt;
    res_nxt.buzzer_level = buzz_nxt;
    res_nxt.fan_level    = fan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cr_seen_r   <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      lamp_r      <= 1'b0;
      buzz_r      <= 1'b0;
      fan_r       <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        cr_seen_r   <= cr_seen_nxt;
        count_r     <= count_nxt;
        head_r      <= head_nxt;
        lamp_r      <= lamp_nxt;
        buzz_r      <= buzz_nxt;
        fan_r       <= fan_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.line_done         = out_res_r.line_done;
  assign out_ch.frame_error       = out_res_r.frame_error;
  assign out_ch.count_wrapped     = out_res_r.count_wrapped;
  assign out_ch.ev_eeprom_history = out_res_r.ev_eeprom_history;
  assign out_ch.ev_flash_store    = out_res_r.ev_flash_store;
  assign out_ch.ev_flash_history  = out_res_r.ev_flash_history;
  assign out_ch.ev_show_page_two  = out_res_r.ev_show_page_two;
  assign out_ch.ev_show_data      = out_res_r.ev_show_data;
  assign out_ch.lamp_level        = out_res_r.lamp_level;
  assign out_ch.buzzer_level      = out_res_r.buzzer_level;
  assign out_ch.fan_level         = out_res_r.fan_level;

  // line end, framing error and wrap never share a beat
  `CRLFCMD_ASSERT_NOW(a_status_exclusive, out_valid_r,
    !(out_res_r.line_done && out_res_r.frame_error) &&
    !(out_res_r.line_done && out_res_r.count_wrapped) &&
    !(out_res_r.frame_error && out_res_r.count_wrapped),
    "status flags overlap")
  `CRLFCMD_ASSERT_NOW(a_events_on_line_end, out_valid_r && !out_res_r.line_done,
    !out_res_r.ev_eeprom_history && !out_res_r.ev_flash_store &&
    !out_res_r.ev_flash_history && !out_res_r.ev_show_page_two &&
    !out_res_r.ev_show_data,
    "command event outside a line end")
  `CRLFCMD_ASSERT_NEXT(a_head_cleared, s1_fire && res_nxt.line_done,
    head_r == '0 && count_r == '0 && !cr_seen_r,
    "line state not cleared after line end")
  `CRLFCMD_ASSERT_NEXT(a_state_held, !s1_fire,
    $stable(cr_seen_r) && $stable(count_r) && $stable(head_r) && $stable(lamp_r),
    "line state moved without a byte")

endmodule

// ===== sim/crlfcmd_status_checker.sv =====
`timescale 1ns / 1ps
// Checker for the CR-LF line decoder: predicts every status beat and compares it field by field.
module crlfcmd_status_checker (
  input  logic   clk,
  input  logic   rst_n,
  crlfcmd_in_if  in_mon,
  crlfcmd_out_if out_mon,
  output int     mismatches,
  output int     beats_due
);
  import crlfcmd_pkg::*;

  localparam int NUM_FIELDS = $bits(result_t);
  localparam int MAX_REPORTS = 40;

  // most significant field first, as in result_t
  string field_names [NUM_FIELDS] = '{
    "line_done", "frame_error", "count_wrapped", "ev_eeprom_history",
    "ev_flash_store", "ev_flash_history", "ev_show_page_two", "ev_show_data",
    "lamp_level", "buzzer_level", "fan_level"
  };

  logic        cr_pending;
  int unsigned line_len;
  logic [7:0]  line_head [HEAD_DEPTH];
  logic        lamp_on;
  logic        buzzer_on;
  logic        fan_on;
  result_t     status_due [$];
  int          fail_total = 0;

  task automatic report(input string what);
    if (fail_total < MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    fail_total++;
  endtask

  function automatic bit head_begins(input string kw);
    for (int i = 0; i < kw.len(); i++) begin
      if (i >= HEAD_DEPTH) return 1'b0;
      if (line_head[i] != kw[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    result_t st;
    st = '0;
    if (cr_pending) begin
      if (b != CHR_LF) begin
        st.frame_error = 1'b1;
      end else begin
        st.line_done         = 1'b1;
        st.ev_eeprom_history = head_begins("at24history");
        st.ev_flash_store    = head_begins("stinw25");
        st.ev_flash_history  = head_begins("w25history");
        st.ev_show_page_two  = head_begins("showpage2");
        st.ev_show_data      = head_begins("showdata");
        if (head_begins("openflowled"))   lamp_on = 1'b1;
        if (head_begins("closeflowled"))  lamp_on = 1'b0;
        if (head_begins("openflowbeep"))  buzzer_on = 1'b1;
        if (head_begins("closeflowbeep")) buzzer_on = 1'b0;
        if (head_begins("openflowfan"))   fan_on = 1'b1;
        if (head_begins("closeflowfan"))  fan_on = 1'b0;
        for (int i = 0; i < HEAD_DEPTH; i++) line_head[i] = '0;
      end
      cr_pending = 1'b0;
      line_len = 0;
    end else if (b == CHR_CR) begin
      cr_pending = 1'b1;
    end else begin
      // head is kept across aborts and wraps
      if (line_len < HEAD_DEPTH) line_head[line_len] = b;
      line_len++;
      if (line_len >= LINE_CAPACITY) begin
        line_len = 0;
        st.count_wrapped = 1'b1;
      end
    end
    st.lamp_level   = lamp_on;
    st.buzzer_level = buzzer_on;
    st.fan_level    = fan_on;
    status_due.push_back(st);
  endtask

  task automatic check_beat();
    result_t got;
    result_t want;
    got = result_t'({out_mon.line_done, out_mon.frame_error, out_mon.count_wrapped,
                     out_mon.ev_eeprom_history, out_mon.ev_flash_store,
                     out_mon.ev_flash_history, out_mon.ev_show_page_two,
                     out_mon.ev_show_data, out_mon.lamp_level, out_mon.buzzer_level,
                     out_mon.fan_level});
    if (status_due.size() == 0) begin
      report($sformatf("status beat %b with nothing outstanding", got));
      return;
    end
    want = status_due.pop_front();
    for (int k = NUM_FIELDS - 1; k >= 0; k--) begin
      if (got[k] !== want[k]) begin
        report($sformatf("%s got %b, expected %b", field_names[NUM_FIELDS - 1 - k],
                         got[k], want[k]));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cr_pending = 1'b0;
      line_len   = 0;
      lamp_on    = 1'b0;
      buzzer_on  = 1'b0;
      fan_on     = 1'b0;
      for (int i = 0; i < HEAD_DEPTH; i++) line_head[i] = '0;
      status_due.delete();
    end else begin
      // push before pop so a beat presented in the same cycle as its byte would still line up
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.rx_byte);
      if (out_mon.valid && out_mon.ready) check_beat();
    end
    mismatches <= fail_total;
    beats_due  <= status_due.size();
  end

endmodule

// ===== sim/crlf_line_command_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the CR-LF line decoder testbench: clock, reset, byte stimulus, result stalls, verdict.
module crlf_line_command_decoder_unit_test;
  import crlfcmd_pkg::*;

  localparam int ITEMS      = 1250;
  localparam int QUIET_TAIL = 150;
  localparam int LIMIT      = 200000;

  string commands [11] = '{
    "at24history", "stinw25", "w25history", "showpage2", "showdata",
    "openflowled", "closeflowled", "openflowbeep", "closeflowbeep",
    "openflowfan", "closeflowfan"
  };

  logic clk = 1'b0;
  logic rst_n;
  logic idling_on;
  int   bytes_sent = 0;
  int   cycles = 0;
  int   mismatches;
  int   beats_due;
  int   stall_left = 0;
  bit   long_done = 1'b0;

  crlfcmd_in_if  in_ch ();
  crlfcmd_out_if out_ch ();

  crlf_line_command_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  crlfcmd_status_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .beats_due  (beats_due)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_data_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CHR_CR) b = CHR_LF;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CHR_CR);
    send_byte(CHR_LF);
  endtask

  task automatic send_random_sequence();
    string      kw;
    int         pick;
    int         pos;
    logic [7:0] b;
    kw   = commands[$urandom_range(0, 10)];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 9))
        6: begin
          send_text(kw);
          repeat ($urandom_range(1, 20)) send_byte(rand_data_byte());
          send_byte(CHR_CR);
          send_byte(CHR_LF);
        end
        7: send_line(kw.substr(0, $urandom_range(0, kw.len() - 2)));
        8: begin
          pos = $urandom_range(0, kw.len() - 1);
          kw[pos] = kw[pos] ^ (8'h01 << $urandom_range(0, 7));
          send_line(kw);
        end
        9: begin
          send_byte(rand_data_byte());
          send_line(kw);
        end
        default: send_line(kw);
      endcase
    end else if (pick < 70) begin
      // aborted line, often followed by an empty line that sees the stale head
      send_text(kw.substr(0, $urandom_range(0, kw.len() - 1)));
      send_byte(CHR_CR);
      b = 8'($urandom_range(0, 255));
      if (b == CHR_LF) b = CHR_CR;
      send_byte(b);
      if ($urandom_range(0, 1) == 1) begin
        send_byte(CHR_CR);
        send_byte(CHR_LF);
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 16)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 30)) send_byte(rand_data_byte());
      send_byte(CHR_CR);
      send_byte(CHR_LF);
    end
  endtask

  initial begin
    string kw;
    rst_n         <= 1'b0;
    idling_on     <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CHR_LF);   // bare LF is just data
    send_byte(CHR_CR);
    send_byte(CHR_CR);   // CR after CR is a framing error
    send_byte(CHR_CR);
    send_byte(8'h41);
    send_line("stinw25");
    send_byte(CHR_CR);   // empty line after a cleared head
    send_byte(CHR_LF);

    while (bytes_sent < ITEMS) begin
      idling_on <= (bytes_sent < ITEMS - QUIET_TAIL) && ((bytes_sent / 200) % 3 != 1);
      if (!long_done && bytes_sent > 300) begin
        // one line long enough to wrap the count; a short tail may leave the keyword intact
        kw = commands[$urandom_range(0, 10)];
        send_text(kw);
        repeat (LINE_CAPACITY - kw.len() + $urandom_range(0, 2)) send_byte(rand_data_byte());
        send_byte(CHR_CR);
        send_byte(CHR_LF);
        long_done = 1'b1;
      end else begin
        send_random_sequence();
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
